/* design/fraction_reduce_gcd_macros.svh */
// fraction_reduce_gcd_macros.svh: assertion macros shared by the fraction reducer.
// Expects aclk and aresetn to be in scope where the macros are used.
`ifndef FRACTION_REDUCE_GCD_MACROS_SVH
`define FRACTION_REDUCE_GCD_MACROS_SVH

// Same-cycle implication, checked outside reset
`define FRG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define FRG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/frg_pkg.sv */
// frg_pkg: shared types for the fraction reducer.
// Used by frg_divider and fraction_reduce_gcd; depends on nothing.
package frg_pkg;

    // Status of the shared iterative divider
    typedef struct packed {
        logic busy;   // a division is stepping
        logic done;   // quotient and remainder valid this cycle
    } div_stat_t;

endpackage

/* design/frg_divider.sv */
// frg_divider: restoring unsigned divider, one quotient bit per cycle.
// Depends on frg_pkg for its status struct.
module frg_divider #(
    parameter int W = 31
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [W-1:0]       dividend,
    input  logic [W-1:0]       divisor,
    output logic [W-1:0]       quotient,
    output logic [W-1:0]       remainder,
    output frg_pkg::div_stat_t stat
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    // Shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = CW'(W);
        end else if (cnt_reg != '0) begin
            // Keep the difference when it did not go negative
            if (!diff[W]) begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - CW'(1);
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

/* design/fraction_reduce_gcd.sv */
// fraction_reduce_gcd: reduces a fraction to lowest terms with Euclid's algorithm.
// Depends on frg_pkg, frg_divider and fraction_reduce_gcd_macros.svh.
//
// Usage:
//   The s_ channel takes one fraction per beat: s_tdata holds the numerator
//   and the denominator. The m_ channel returns one beat per input with the
//   reduced numerator, reduced denominator and the greatest common divisor in
//   m_tdata, and the zero-denominator flag in m_tuser.
//   All arithmetic runs on one shared restoring divider that yields one
//   quotient bit per cycle. The greatest common divisor takes k remainder
//   steps (k is data dependent, at most about 1.44 * VALUE_BITS), followed
//   by two divisions. A zero denominator skips all division, passes through
//   the finish step into the output register with the flag set and all data
//   fields zero.
//   s_tready is high only while no item is in work; one item is handled at a
//   time. The result sits in an output register: the next item may be taken
//   while it waits, and a finished result waits until the register is free.
//   A stalled m_tready holds the result beat unchanged.
//   Reset (aresetn low, synchronous) drops any item in work and any pending
//   result; the block then stands ready.
`include "fraction_reduce_gcd_macros.svh"

module fraction_reduce_gcd #(
    parameter int VALUE_BITS = 31
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // num_in [VALUE_BITS-1:0], den_in [2*VALUE_BITS-1:VALUE_BITS], zero pad above
    input  logic [((2 * VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // num_out, den_out, divisor_found from bit 0 up, VALUE_BITS each, zero pad above
    output logic [((3 * VALUE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // zero_den_error
    output logic                   m_tuser
);

    localparam int W           = VALUE_BITS;
    localparam int IN_TDATA_W  = ((2 * VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3 * VALUE_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD_STEP,
        ST_GCD_WAIT,
        ST_NUM_START,
        ST_NUM_WAIT,
        ST_DEN_START,
        ST_DEN_WAIT,
        ST_FINISH
    } state_t;

    state_t        state_reg, state_next;
    logic [W-1:0]  n_reg, n_next;
    logic [W-1:0]  d_reg, d_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  numq_reg, numq_next;
    logic [W-1:0]  denq_reg, denq_next;
    logic          err_reg, err_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic          m_tuser_reg, m_tuser_next;

    logic          div_start;
    logic [W-1:0]  div_dividend;
    logic [W-1:0]  div_divisor;
    logic [W-1:0]  div_quo;
    logic [W-1:0]  div_rem;
    frg_pkg::div_stat_t div_stat;

    logic [W-1:0]  s_num;
    logic [W-1:0]  s_den;
    logic          s_beat;
    logic          out_free;

    assign s_num    = s_tdata[W-1:0];
    assign s_den    = s_tdata[2*W-1:W];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    frg_divider #(.W(W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    // Steer the divider operands by sequencer step
    always_comb begin
        case (state_reg)
            ST_NUM_START: begin
                div_dividend = n_reg;
                div_divisor  = a_reg;
            end
            ST_DEN_START: begin
                div_dividend = d_reg;
                div_divisor  = a_reg;
            end
            default: begin
                div_dividend = a_reg;
                div_divisor  = b_reg;
            end
        endcase
    end

    // Sequencer: Euclid remainder steps, then the two reducing divisions
    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        d_next        = d_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        numq_next     = numq_reg;
        denq_next     = denq_reg;
        err_next      = err_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        div_start     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    n_next = s_num;
                    d_next = s_den;
                    a_next = s_num;
                    b_next = s_den;
                    if (s_den == '0) begin
                        // Zero denominator: flag it, report zeros
                        err_next   = 1'b1;
                        a_next     = '0;
                        numq_next  = '0;
                        denq_next  = '0;
                        state_next = ST_FINISH;
                    end else begin
                        err_next   = 1'b0;
                        state_next = ST_GCD_STEP;
                    end
                end
            end
            ST_GCD_STEP: begin
                // A zero remainder leaves the divisor in a
                if (b_reg == '0) begin
                    state_next = ST_NUM_START;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_GCD_WAIT;
                end
            end
            ST_GCD_WAIT: begin
                if (div_stat.done) begin
                    a_next     = b_reg;
                    b_next     = div_rem;
                    state_next = ST_GCD_STEP;
                end
            end
            ST_NUM_START: begin
                div_start  = 1'b1;
                state_next = ST_NUM_WAIT;
            end
            ST_NUM_WAIT: begin
                if (div_stat.done) begin
                    numq_next  = div_quo;
                    state_next = ST_DEN_START;
                end
            end
            ST_DEN_START: begin
                div_start  = 1'b1;
                state_next = ST_DEN_WAIT;
            end
            ST_DEN_WAIT: begin
                if (div_stat.done) begin
                    denq_next  = div_quo;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // Hold until the output register is free
                if (out_free) begin
                    m_tdata_next  = OUT_TDATA_W'({a_reg, denq_reg, numq_reg});
                    m_tuser_next  = err_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        d_reg       <= d_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        numq_reg    <= numq_next;
        denq_reg    <= denq_next;
        err_reg     <= err_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Error beats carry all-zero data
    `FRG_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser, m_tdata == '0, "error beat with data")
    // Good beats carry a nonzero divisor and denominator
    `FRG_ASSERT_NOW(a_good_nonzero, m_tvalid && !m_tuser,
        (m_tdata[3*W-1:2*W] != '0) && (m_tdata[2*W-1:W] != '0), "zero divisor on good beat")
    // The divider is quiet whenever input is taken
    `FRG_ASSERT_NOW(a_idle_quiet, s_tready, !div_stat.busy && !div_stat.done,
        "divider active while idle")
    // Divider results only arrive while a wait step expects them
    `FRG_ASSERT_NOW(a_done_expected, div_stat.done,
        (state_reg == ST_GCD_WAIT) || (state_reg == ST_NUM_WAIT) || (state_reg == ST_DEN_WAIT),
        "unexpected divider result")
    // A started division runs
    `FRG_ASSERT_NEXT(a_start_busy, div_start, div_stat.busy, "divider did not start")

endmodule
